// File: rtl/kway_merge_min_heap_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the k-way merge heap
// Shared forms of concurrent checks, clocked and reset-qualified.
// ----------------------------------------------------------------------------
`ifndef KWAY_MERGE_MIN_HEAP_ASSERT_SVH
`define KWAY_MERGE_MIN_HEAP_ASSERT_SVH

// same-cycle implication
`define KMH_ASSERT_IMP(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define KMH_ASSERT_NXT(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: rtl/kmh_pkg.sv
// ----------------------------------------------------------------------------
// kmh_pkg
// Types, codes and the ordering function of the k-way merge heap.
// ----------------------------------------------------------------------------
package kmh_pkg;

    typedef enum logic [1:0] {
        ACT_LOAD    = 2'd0,
        ACT_REPLACE = 2'd1,
        ACT_EXHAUST = 2'd2,
        ACT_CLEAR   = 2'd3
    } act_t;

    typedef enum logic [1:0] {
        STAT_OK   = 2'd0,
        STAT_END  = 2'd1,
        STAT_FULL = 2'd2
    } stat_t;

    typedef struct packed {
        logic [63:0] payload;
        logic [3:0]  source;
        logic [63:0] rtime;
    } entry_t;

    localparam int unsigned EntryW = $bits(entry_t);

    // signed time first, lower source wins ties
    function automatic logic ent_less(input entry_t a, input entry_t b);
        logic [67:0] ka;
        logic [67:0] kb;
        ka = {~a.rtime[63], a.rtime[62:0], a.source};
        kb = {~b.rtime[63], b.rtime[62:0], b.source};
        return ka < kb;
    endfunction

endpackage

// File: rtl/kway_merge_min_heap.sv
// Each request walks the heap level by level: load sifts the new entry up, replace
// and exhaust sift the root entry down, and clear resets the fill count.
// A new request is taken only once the previous result has been accepted; the
// single RAM read port and the shared comparator set the per-level cost.
// Reset: synchronous active-low aresetn empties the heap and drops any result;
// the node RAM is not cleared.
// ----------------------------------------------------------------------------
// kway_merge_min_heap
// K-way merge engine over a binary min-heap of stream heads kept in RAM.
// ----------------------------------------------------------------------------
module kway_merge_min_heap
    import kmh_pkg::*;
#(
    parameter int WAYS = 16
) (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [135:0] s_tdata,   // rec_time[63:0], source_id[67:64], rec_payload[131:68]
    input  logic [1:0]   s_tuser,   // action[1:0]
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [143:0] m_tdata,   // top_time[63:0], top_source[67:64],
                                    // top_payload[131:68], fill_count[136:132]
    output logic [2:0]   m_tuser    // top_valid[0], status[2:1]
);

    localparam int IW = (WAYS > 1) ? $clog2(WAYS) : 1;
    localparam int CW = $clog2(WAYS + 1);
    localparam int XW = IW + 2;

    typedef enum logic [3:0] {
        S_IDLE, S_UP, S_UP_CMP, S_DN_RDL, S_DN_RDR, S_DN_CMP, S_DN_SEL,
        S_LAST_RD, S_LAST_WT, S_DONE
    } state_t;

    state_t          state_reg;
    logic [CW-1:0]   cnt_reg;
    logic [IW-1:0]   pos_reg;
    logic [IW-1:0]   cidx_reg;
    entry_t          item_reg;
    entry_t          cand_reg;
    entry_t          top_reg;
    logic            drop_reg;
    logic            m_valid_reg;
    logic [143:0]    m_data_reg;
    logic [2:0]      m_user_reg;

    logic            wr_en;
    logic [IW-1:0]   wr_addr;
    entry_t          wr_data;
    logic [IW-1:0]   rd_addr;
    logic [EntryW-1:0] rd_raw;
    entry_t          rd_data;
    entry_t          cmp_a;
    entry_t          cmp_b;
    logic            less;
    logic [XW-1:0]   lchild;
    logic [XW-1:0]   rchild;
    logic [IW-1:0]   parent;
    logic            accept;
    entry_t          in_ent;
    act_t            in_act;

    kmh_ram #(.WIDTH(EntryW), .DEPTH(WAYS)) u_ram (
        .aclk    (aclk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_addr (rd_addr),
        .rd_data (rd_raw)
    );

    assign rd_data = entry_t'(rd_raw);
    assign lchild  = XW'({pos_reg, 1'b1});
    assign rchild  = lchild + XW'(1);
    assign parent  = (pos_reg - IW'(1)) >> 1;
    assign accept  = s_tvalid && s_tready;
    assign in_act  = act_t'(s_tuser);
    assign in_ent  = '{payload: s_tdata[131:68], source: s_tdata[67:64],
                       rtime: s_tdata[63:0]};
    assign less    = ent_less(cmp_a, cmp_b);

    always_comb begin
        cmp_a   = cand_reg;
        cmp_b   = item_reg;
        wr_en   = 1'b0;
        wr_addr = pos_reg;
        wr_data = item_reg;
        rd_addr = '0;
        case (state_reg)
            S_UP: begin
                wr_en   = (pos_reg == '0);
                rd_addr = parent;
            end
            S_UP_CMP: begin
                cmp_a   = item_reg;
                cmp_b   = rd_data;
                wr_en   = 1'b1;
                wr_data = less ? rd_data : item_reg;
            end
            S_DN_RDL: begin
                wr_en   = (lchild >= XW'(cnt_reg));
                rd_addr = lchild[IW-1:0];
            end
            S_DN_RDR: begin
                rd_addr = rchild[IW-1:0];
            end
            S_DN_CMP: begin
                cmp_a = rd_data;
                cmp_b = cand_reg;
            end
            S_DN_SEL: begin
                wr_en   = 1'b1;
                wr_data = less ? cand_reg : item_reg;
            end
            S_LAST_RD: begin
                rd_addr = cnt_reg[IW-1:0];
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            cnt_reg     <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            if (m_valid_reg && m_tready) begin
                m_valid_reg <= 1'b0;
            end
            if (wr_en && wr_addr == '0) begin
                top_reg <= wr_data;
            end
            case (state_reg)
                S_IDLE: begin
                    if (accept) begin
                        drop_reg <= 1'b0;
                        pos_reg  <= '0;
                        state_reg <= S_DONE;
                        case (in_act)
                            ACT_LOAD: begin
                                if (cnt_reg == CW'(WAYS)) begin
                                    drop_reg <= 1'b1;
                                end else begin
                                    item_reg  <= in_ent;
                                    pos_reg   <= cnt_reg[IW-1:0];
                                    cnt_reg   <= cnt_reg + CW'(1);
                                    state_reg <= S_UP;
                                end
                            end
                            ACT_REPLACE: begin
                                if (cnt_reg != '0) begin
                                    item_reg  <= '{payload: in_ent.payload,
                                                   source: top_reg.source,
                                                   rtime: in_ent.rtime};
                                    state_reg <= S_DN_RDL;
                                end
                            end
                            ACT_EXHAUST: begin
                                if (cnt_reg != '0) begin
                                    cnt_reg <= cnt_reg - CW'(1);
                                    if (cnt_reg != CW'(1)) begin
                                        state_reg <= S_LAST_RD;
                                    end
                                end
                            end
                            default: begin
                                cnt_reg <= '0;
                            end
                        endcase
                    end
                end
                S_UP: begin
                    cidx_reg  <= parent;
                    state_reg <= (pos_reg == '0) ? S_DONE : S_UP_CMP;
                end
                S_UP_CMP: begin
                    if (less) begin
                        pos_reg   <= cidx_reg;
                        state_reg <= S_UP;
                    end else begin
                        state_reg <= S_DONE;
                    end
                end
                S_DN_RDL: begin
                    state_reg <= (lchild >= XW'(cnt_reg)) ? S_DONE : S_DN_RDR;
                end
                S_DN_RDR: begin
                    cand_reg  <= rd_data;
                    cidx_reg  <= lchild[IW-1:0];
                    state_reg <= (rchild < XW'(cnt_reg)) ? S_DN_CMP : S_DN_SEL;
                end
                S_DN_CMP: begin
                    if (less) begin
                        cand_reg <= rd_data;
                        cidx_reg <= rchild[IW-1:0];
                    end
                    state_reg <= S_DN_SEL;
                end
                S_DN_SEL: begin
                    if (less) begin
                        pos_reg   <= cidx_reg;
                        state_reg <= S_DN_RDL;
                    end else begin
                        state_reg <= S_DONE;
                    end
                end
                S_LAST_RD: begin
                    state_reg <= S_LAST_WT;
                end
                S_LAST_WT: begin
                    item_reg  <= rd_data;
                    pos_reg   <= '0;
                    state_reg <= S_DN_RDL;
                end
                S_DONE: begin
                    m_valid_reg <= 1'b1;
                    if (cnt_reg != '0) begin
                        m_data_reg <= {7'd0, 5'(cnt_reg), top_reg.payload,
                                       top_reg.source, top_reg.rtime};
                    end else begin
                        m_data_reg <= {7'd0, 5'(cnt_reg), 132'd0};
                    end
                    m_user_reg[0] <= (cnt_reg != '0);
                    if (drop_reg) begin
                        m_user_reg[2:1] <= STAT_FULL;
                    end else if (cnt_reg == '0) begin
                        m_user_reg[2:1] <= STAT_END;
                    end else begin
                        m_user_reg[2:1] <= STAT_OK;
                    end
                    state_reg <= S_IDLE;
                end
                default: begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign s_tready = (state_reg == S_IDLE) && !m_valid_reg;
    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;
    assign m_tuser  = m_user_reg;

endmodule

// File: rtl/kmh_ram.sv
// ----------------------------------------------------------------------------
// kmh_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module kmh_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     aclk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

// File: rtl/kmh_chk.sv
// ----------------------------------------------------------------------------
// kmh_chk
// Port-level checks of the k-way merge heap, bound to the top level.
// ----------------------------------------------------------------------------
`include "kway_merge_min_heap_assert.svh"

module kmh_chk
    import kmh_pkg::*;
#(
    parameter int WAYS = 16
) (
    input logic         aclk,
    input logic         aresetn,
    input logic         s_tvalid,
    input logic         s_tready,
    input logic         m_tvalid,
    input logic         m_tready,
    input logic [143:0] m_tdata,
    input logic [2:0]   m_tuser
);

    logic [4:0] fill_cnt;
    logic [1:0] res_stat;
    logic       top_vld;
    logic       empty;
    logic       heap_full;
    logic       st_full;
    logic       st_end;
    logic       m_stall;

    assign fill_cnt  = m_tdata[136:132];
    assign res_stat  = m_tuser[2:1];
    assign top_vld   = m_tuser[0];
    assign empty     = (fill_cnt == 5'd0);
    assign heap_full = (fill_cnt == 5'(WAYS));
    assign st_full   = (res_stat == STAT_FULL);
    assign st_end    = (res_stat == STAT_END);
    assign m_stall   = m_tvalid && !m_tready;

    `KMH_ASSERT_IMP(a_top, aclk, aresetn, m_tvalid, top_vld == !empty, "bad top_valid")
    `KMH_ASSERT_IMP(a_end, aclk, aresetn, m_tvalid && !st_full, st_end == empty, "bad end status")
    `KMH_ASSERT_IMP(a_full, aclk, aresetn, m_tvalid && st_full, heap_full, "bad full status")
    `KMH_ASSERT_NXT(a_busy, aclk, aresetn, s_tvalid && s_tready, !s_tready, "accept while busy")
    `KMH_ASSERT_NXT(a_hold, aclk, aresetn, m_stall, m_tvalid && $stable(m_tdata), "result not held")

endmodule

bind kway_merge_min_heap kmh_chk #(.WAYS(WAYS)) u_kmh_chk (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);
